/* rtl/bpst_pkg.sv */
// Package for the band peak slew tracker: widths, register indexes and helpers.
// No dependencies.
package bpst_pkg;
    localparam int MaxBandsDef      = 8;
    localparam int MaxBandLengthDef = 4096;
    localparam int SampleW = 16;
    localparam int PeakW   = 15;
    localparam int RatioW  = 16;
    localparam int SmoothW = 18;
    localparam int CountW  = 4;
    localparam int LengthW = 13;
    localparam int PeriodW = 8;
    localparam int StepW   = 15;
    localparam int CdW     = 9;
    localparam int AddrW   = 4;

    typedef enum logic [1:0] {
        REG_BAND_COUNT   = 2'd0,
        REG_BAND_LENGTH  = 2'd1,
        REG_REFRESH      = 2'd2,
        REG_SMOOTH_STEP  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic       sample_en;   // take in one sample
        logic       frame_clr;   // clear running peaks and position
        logic       commit_en;   // load commit of current slot, or start average divide
        logic       div_start;   // start ratio divide for slot
        logic       div_done_ld; // store divider result
        logic       slew_en;     // slew current slot
        logic       avg_sel;     // slot is the average
        logic [2:0] slot;        // band under work
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic avg_busy;
    } t_sts;
endpackage

/* rtl/bpst_div.sv */
// Serial restoring divider, one quotient bit per cycle.
// Depends on bpst_pkg.
module bpst_div import bpst_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [23:0]       i_num,
    input  logic [PeakW-1:0]  i_den,
    output logic              o_busy,
    output logic [23:0]       o_quo
);
    logic [23:0]      r_q;
    logic [PeakW:0]   r_rem;
    logic [PeakW-1:0] r_den;
    logic [4:0]       r_cnt;
    logic [PeakW+1:0] w_trial;
    logic [PeakW:0]   w_shift;

    assign w_shift = {r_rem[PeakW-1:0], r_q[23]};
    assign w_trial = {1'b0, w_shift} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 5'd24;
        end else if (r_cnt != 0) begin
            r_cnt <= r_cnt - 5'd1;
        end
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != 0) begin
            if (!w_trial[PeakW+1]) begin
                r_rem <= w_trial[PeakW:0];
                r_q   <= {r_q[22:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_q   <= {r_q[22:0], 1'b0};
            end
        end
    end
    assign o_busy = (r_cnt != 0) || i_start;
    assign o_quo  = r_q;
endmodule

/* rtl/bpst_datapath.sv */
// Datapath: band accumulation, commit, ratio, average, slew and result fields.
// Depends on bpst_pkg and bpst_div.
module bpst_datapath import bpst_pkg::*; #(
    parameter int MAX_BANDS = MaxBandsDef,
    parameter int MAX_BAND_LENGTH = MaxBandLengthDef
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    input  logic signed [SampleW-1:0] i_sample,
    input  logic [CountW-1:0]         i_count,
    input  logic [LengthW-1:0]        i_length,
    input  logic [StepW-1:0]          i_step,
    output logic [PeakW-1:0]          o_peak,
    output logic [RatioW-1:0]         o_ratio,
    output logic signed [SmoothW-1:0] o_smooth
);
    localparam int BW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int OW = (MAX_BAND_LENGTH > 1) ? $clog2(MAX_BAND_LENGTH) : 1;
    localparam int LW = $clog2(MAX_BAND_LENGTH + 1);

    logic [PeakW-1:0]   r_run  [MAX_BANDS];
    logic [PeakW-1:0]   r_cpk  [MAX_BANDS];
    logic [PeakW-1:0]   r_prev [MAX_BANDS];
    logic [RatioW-1:0]  r_rat  [MAX_BANDS];
    logic signed [SmoothW-1:0] r_sm [MAX_BANDS];
    logic [PeakW-1:0]   r_avg, r_pavg;
    logic [RatioW-1:0]  r_arat;
    logic signed [SmoothW-1:0] r_asm;
    logic [3:0]         r_pos;
    logic [OW:0]        r_off;
    logic               r_full;
    logic [PeakW+3:0]   r_sum;

    logic [3:0]  w_cnt;
    logic [LW-1:0] w_len;
    always_comb begin
        if (i_count == 0) w_cnt = 4'd1;
        else if (32'(i_count) > MAX_BANDS) w_cnt = 4'(MAX_BANDS);
        else w_cnt = i_count;
        if (i_length == 0) w_len = LW'(1);
        else if (32'(i_length) > MAX_BAND_LENGTH) w_len = LW'(MAX_BAND_LENGTH);
        else w_len = LW'(i_length);
    end

    // average divide: restoring, one quotient bit per cycle, quotient shifts into r_sum
    logic [4:0]       r_acnt;
    logic [3:0]       r_arem;
    logic             r_abusy;
    logic [4:0]       w_ashift;
    assign w_ashift = {r_arem, r_sum[PeakW+3]};

    logic [BW-1:0] w_slot;
    logic [BW-1:0] w_pidx;
    assign w_slot = i_cmd.slot[BW-1:0];
    assign w_pidx = r_pos[BW-1:0];

    logic [PeakW-1:0] w_now, w_den;
    assign w_now = i_cmd.avg_sel ? r_avg  : r_cpk[w_slot];
    assign w_den = i_cmd.avg_sel ? r_pavg : r_prev[w_slot];

    logic        w_dbusy;
    logic [23:0] w_quo;
    bpst_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  ({w_now, 8'd0, 1'b0} >> 1),
        .i_den  (w_den),
        .o_busy (w_dbusy),
        .o_quo  (w_quo)
    );
    logic [RatioW-1:0] w_rsat;
    assign w_rsat = (w_quo[23:16] != 0) ? '1 : w_quo[15:0];

    logic signed [SmoothW-1:0] w_cur;
    logic [PeakW-1:0]          w_tgt;
    logic signed [SmoothW+1:0] w_sl;
    assign w_cur = i_cmd.avg_sel ? r_asm : r_sm[w_slot];
    assign w_tgt = i_cmd.avg_sel ? r_avg : r_cpk[w_slot];
    always_comb begin
        if ($signed({3'b0, w_tgt}) > w_cur)
            w_sl = 20'(w_cur) + $signed({5'b0, i_step});
        else
            w_sl = 20'(w_cur) - $signed({5'b0, i_step});
    end
    logic signed [SmoothW-1:0] w_slsat;
    always_comb begin
        if (w_sl > 20'sd131071) w_slsat = 18'sd131071;
        else if (w_sl < -20'sd131072) w_slsat = -18'sd131072;
        else w_slsat = w_sl[SmoothW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_BANDS; k++) begin
                r_run[k] <= '0; r_cpk[k] <= '0; r_prev[k] <= '0;
                r_rat[k] <= '0; r_sm[k] <= '0;
            end
            r_avg <= '0; r_pavg <= '0; r_arat <= '0; r_asm <= '0;
            r_pos <= '0; r_off <= '0; r_full <= 1'b0;
            r_sum <= '0; r_acnt <= '0; r_arem <= '0; r_abusy <= 1'b0;
        end else begin
            if (i_cmd.sample_en) begin
                if (!r_full && r_pos < w_cnt) begin
                    if (i_sample > 0 && i_sample[PeakW-1:0] > r_run[w_pidx])
                        r_run[w_pidx] <= i_sample[PeakW-1:0];
                    if (32'(r_off) + 1 >= 32'(w_len)) begin
                        r_off <= '0;
                        if (r_pos + 4'd1 >= w_cnt) r_full <= 1'b1;
                        else r_pos <= r_pos + 4'd1;
                    end else begin
                        r_off <= r_off + 1'b1;
                    end
                end else begin
                    r_full <= 1'b1;
                end
            end
            if (i_cmd.commit_en) begin
                if (i_cmd.avg_sel) begin
                    // start average divide
                    r_acnt  <= 5'(PeakW + 4);
                    r_arem  <= '0;
                    r_abusy <= 1'b1;
                end else begin
                    r_cpk[w_slot] <= r_run[w_slot];
                    r_sum <= ((i_cmd.slot == 0) ? '0 : r_sum) + 19'(r_run[w_slot]);
                end
            end else if (r_abusy) begin
                if (r_acnt != 0) begin
                    r_acnt <= r_acnt - 5'd1;
                    if (w_ashift >= {1'b0, w_cnt}) begin
                        r_arem <= 4'(w_ashift - {1'b0, w_cnt});
                        r_sum  <= {r_sum[PeakW+2:0], 1'b1};
                    end else begin
                        r_arem <= w_ashift[3:0];
                        r_sum  <= {r_sum[PeakW+2:0], 1'b0};
                    end
                end else begin
                    r_abusy <= 1'b0;
                    r_avg   <= r_sum[PeakW-1:0];
                end
            end
            if (i_cmd.div_done_ld) begin
                if (i_cmd.avg_sel) begin
                    if (r_pavg != 0) r_arat <= w_rsat;
                    r_pavg <= r_avg;
                end else begin
                    if (r_prev[w_slot] != 0) r_rat[w_slot] <= w_rsat;
                    r_prev[w_slot] <= r_cpk[w_slot];
                end
            end
            if (i_cmd.slew_en) begin
                if (i_cmd.avg_sel) r_asm <= w_slsat;
                else r_sm[w_slot] <= w_slsat;
            end
            if (i_cmd.frame_clr) begin
                for (int k = 0; k < MAX_BANDS; k++) r_run[k] <= '0;
                r_pos <= '0; r_off <= '0; r_full <= 1'b0;
            end
        end
    end

    assign o_sts.div_busy = w_dbusy;
    assign o_sts.avg_busy = r_abusy;
    assign o_peak   = i_cmd.avg_sel ? r_avg  : r_cpk[w_slot];
    assign o_ratio  = i_cmd.avg_sel ? r_arat : r_rat[w_slot];
    assign o_smooth = i_cmd.avg_sel ? r_asm  : r_sm[w_slot];
endmodule

/* rtl/bpst_ctrl.sv */
// Controller: sequences sample intake, commit, divides, slews and results.
// Depends on bpst_pkg.
module bpst_ctrl import bpst_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_frame_end,
    input  logic [CountW-1:0]  i_count,
    input  logic [PeriodW-1:0] i_period,
    input  logic [3:0]         i_max,
    output t_cmd               o_cmd,
    input  t_sts               i_sts,
    output logic               o_valid,
    input  logic               i_ostall,
    output logic [2:0]         o_band,
    output logic               o_avg,
    output logic               o_last
);
    typedef enum logic [3:0] {
        S_IDLE, S_COMMIT, S_AVG, S_AVGW, S_DIV, S_DIVW, S_SLEW, S_OUT
    } t_state;

    t_state r_state;
    logic [3:0] r_slot;
    logic signed [CdW-1:0] r_cd;
    logic [3:0] w_cnt;
    always_comb begin
        if (i_count == 0) w_cnt = 4'd1;
        else if (i_count > i_max) w_cnt = i_max;
        else w_cnt = i_count;
    end
    logic w_acc;
    assign w_acc = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    logic [3:0] w_last_slot;
    assign w_last_slot = w_cnt; // slot == count means average

    always_comb begin
        o_cmd = '0;
        o_cmd.slot = r_slot[2:0];
        o_cmd.avg_sel = (r_slot == w_last_slot);
        o_cmd.sample_en = w_acc;
        unique case (r_state)
            S_COMMIT: o_cmd.commit_en = !o_cmd.avg_sel;
            S_AVG:    o_cmd.commit_en = 1'b1;
            S_DIV:    o_cmd.div_start = 1'b1;
            S_DIVW:   o_cmd.div_done_ld = !i_sts.div_busy;
            S_SLEW:   begin
                o_cmd.slew_en = 1'b1;
                o_cmd.frame_clr = (r_slot == 0);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_slot <= '0; r_cd <= '0;
            o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (w_acc && i_frame_end) begin
                    r_slot <= '0;
                    if (r_cd - 9'sd1 <= 0) begin
                        r_cd <= $signed({1'b0, i_period});
                        r_state <= S_COMMIT;
                    end else begin
                        r_cd <= r_cd - 9'sd1;
                        r_state <= S_SLEW;
                    end
                end
                S_COMMIT: begin
                    if (r_slot + 4'd1 >= w_cnt) begin
                        r_slot <= w_cnt; r_state <= S_AVG;
                    end else r_slot <= r_slot + 4'd1;
                end
                S_AVG:  r_state <= S_AVGW;
                S_AVGW: if (!i_sts.avg_busy) begin
                    r_slot <= '0; r_state <= S_DIV;
                end
                S_DIV:  r_state <= S_DIVW;
                S_DIVW: if (!i_sts.div_busy) begin
                    if (r_slot == w_cnt) begin
                        r_slot <= '0; r_state <= S_SLEW;
                    end else begin
                        r_slot <= r_slot + 4'd1; r_state <= S_DIV;
                    end
                end
                S_SLEW: begin
                    if (r_slot == w_cnt) begin
                        r_slot <= '0; r_state <= S_OUT; o_valid <= 1'b1;
                    end else r_slot <= r_slot + 4'd1;
                end
                S_OUT: if (!i_ostall) begin
                    if (r_slot == w_cnt) begin
                        o_valid <= 1'b0; r_slot <= '0; r_state <= S_IDLE;
                    end else r_slot <= r_slot + 4'd1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
    assign o_avg  = (r_slot == w_cnt);
    assign o_last = o_avg;
    assign o_band = o_avg ? 3'd0 : r_slot[2:0];
endmodule

/* rtl/band_peak_slew_tracker.sv */
// Channel | handshake         | payload
// in      | i_valid / o_stall | i_sample_value, i_frame_end
// out     | o_valid / i_stall | o_band_index .. o_last_result
// Samples without frame end are taken without raising o_stall. A committing frame end
// runs the commit, a 19-bit serial average divide, one serial 24-bit divide per ratio,
// the slews and the results up to the last result; a frame end without commit runs
// only the slews and the results. Output stalls add to both; input stalls meanwhile.
// Synchronous active-low reset. Depends on bpst_pkg, bpst_ctrl, bpst_datapath.
module band_peak_slew_tracker import bpst_pkg::*; #(
    parameter int MAX_BANDS = MaxBandsDef,
    parameter int MAX_BAND_LENGTH = MaxBandLengthDef
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [SampleW-1:0] i_sample_value,
    input  logic                      i_frame_end,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [2:0]                o_band_index,
    output logic                      o_is_average,
    output logic [PeakW-1:0]          o_peak_level,
    output logic [RatioW-1:0]         o_peak_ratio,
    output logic signed [SmoothW-1:0] o_smooth_level,
    output logic                      o_last_result,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [AddrW-1:0]          paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    logic [CountW-1:0]  r_count;
    logic [LengthW-1:0] r_length;
    logic [PeriodW-1:0] r_period;
    logic [StepW-1:0]   r_step;
    t_cmd w_cmd;
    t_sts w_sts;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 4'd3; r_length <= 13'd170; r_period <= 8'd1; r_step <= 15'd328;
        end else if (psel && penable && pwrite) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_BAND_COUNT:  r_count  <= pwdata[CountW-1:0];
                REG_BAND_LENGTH: r_length <= pwdata[LengthW-1:0];
                REG_REFRESH:     r_period <= pwdata[PeriodW-1:0];
                REG_SMOOTH_STEP: r_step   <= pwdata[StepW-1:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_BAND_COUNT:  prdata = 32'(r_count);
            REG_BAND_LENGTH: prdata = 32'(r_length);
            REG_REFRESH:     prdata = 32'(r_period);
            REG_SMOOTH_STEP: prdata = 32'(r_step);
            default:         prdata = '0;
        endcase
    end

    bpst_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_frame_end(i_frame_end), .i_count(r_count), .i_period(r_period),
        .i_max(4'(MAX_BANDS)), .o_cmd(w_cmd), .i_sts(w_sts), .o_valid(o_valid),
        .i_ostall(i_stall), .o_band(o_band_index), .o_avg(o_is_average),
        .o_last(o_last_result)
    );
    bpst_datapath #(.MAX_BANDS(MAX_BANDS), .MAX_BAND_LENGTH(MAX_BAND_LENGTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_sample(i_sample_value), .i_count(r_count), .i_length(r_length),
        .i_step(r_step), .o_peak(o_peak_level), .o_ratio(o_peak_ratio),
        .o_smooth(o_smooth_level)
    );
endmodule

/* rtl/bpst_checker.sv */
// Port-level checker for the band peak slew tracker, bound to the top level.
// Depends on bpst_pkg.
module bpst_checker import bpst_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_last_result,
    input logic o_is_average,
    input logic [2:0] o_band_index
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("result dropped under stall");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_result |-> o_is_average && o_band_index == 3'd0)
        else $error("last result not average");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input taken while results pending");
endmodule

bind band_peak_slew_tracker bpst_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_last_result(o_last_result),
    .o_is_average(o_is_average), .o_band_index(o_band_index)
);
